>>> sv/assert_macros.svh
// Assertion macros shared by the gain and output stages of the view angle block.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DAC_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DAC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> sv/dac_pkg.sv
// Package of the view angle block: datapath types, sideband structs,
// angle constants and the CORDIC arctangent steps. No dependencies.
`default_nettype none

package dac_pkg;

  localparam int XW = 41;
  localparam int ZW = 27;
  localparam int TAB_FRAC = 16;
  localparam int ANGLE_W = 18;
  localparam int OUT_DATA_W = 40;
  localparam int KINV_W = 22;
  localparam int KINV_SHIFT = 22;
  localparam logic [KINV_W-1:0] KINV_Q22 = 22'd2547003;
  localparam int PROD_SPLIT = 20;

  localparam int DEG_90 = 90;
  localparam int DEG_180 = 180;
  localparam int DEG_270 = 270;
  localparam int DEG_PITCH_MIN = -100;

  typedef logic signed [XW-1:0] cval_t;
  typedef logic signed [ZW-1:0] ang_t;

  typedef struct packed {
    cval_t x;
    cval_t y;
    ang_t  z;
  } vec_t;

  typedef struct packed {
    logic  planar_zero;
    logic  axis;
    logic  dz_pos;
    logic  dz_zero;
    ang_t  yz_ovr;
    cval_t len_ovr;
    cval_t dz_s;
  } yaw_side_t;

  typedef struct packed {
    logic planar_zero;
    logic dz_pos;
    logic dz_zero;
    ang_t yaw_fold;
  } pitch_side_t;

  function automatic ang_t deg(input int d, input int unsigned frac);
    return ang_t'(longint'(d) <<< frac);
  endfunction

  function automatic ang_t round_angle(input ang_t z, input int unsigned afb);
    int unsigned s = TAB_FRAC - afb;
    return (z + (ang_t'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic ang_t atan_step(input int unsigned idx);
    ang_t r;
    case (idx)
      0: r = 27'sd2949120;
      1: r = 27'sd1740967;
      2: r = 27'sd919879;
      3: r = 27'sd466945;
      4: r = 27'sd234379;
      5: r = 27'sd117304;
      6: r = 27'sd58666;
      7: r = 27'sd29335;
      8: r = 27'sd14668;
      9: r = 27'sd7334;
      10: r = 27'sd3667;
      11: r = 27'sd1833;
      12: r = 27'sd917;
      13: r = 27'sd458;
      14: r = 27'sd229;
      15: r = 27'sd115;
      16: r = 27'sd57;
      17: r = 27'sd29;
      18: r = 27'sd14;
      19: r = 27'sd7;
      20: r = 27'sd4;
      21: r = 27'sd2;
      22: r = 27'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> sv/dac_cordic_cell.sv
// One CORDIC vectoring cell with a registered output and a pass-through
// sideband. Depends on dac_pkg.
`default_nettype none

module dac_cordic_cell #(
  parameter int unsigned STAGE  = 0,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  dac_pkg::vec_t     vec_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  input  logic              ready_i,
  output dac_pkg::vec_t     vec_o,
  output logic [SIDE_W-1:0] side_o
);
  import dac_pkg::*;

  logic              valid_q;
  vec_t              vec_d, vec_q;
  logic [SIDE_W-1:0] side_q;
  cval_t             xs, ys;

  always_comb begin
    xs = vec_i.x >>> STAGE;
    ys = vec_i.y >>> STAGE;
    vec_d = vec_i;
    if (!vec_i.y[XW-1]) begin
      vec_d.x = vec_i.x + ys;
      vec_d.y = vec_i.y - xs;
      vec_d.z = vec_i.z + atan_step(STAGE);
    end else begin
      vec_d.x = vec_i.x - ys;
      vec_d.y = vec_i.y + xs;
      vec_d.z = vec_i.z - atan_step(STAGE);
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      vec_q  <= vec_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign vec_o   = vec_q;
  assign side_o  = side_q;

endmodule

`default_nettype wire

>>> sv/dac_prep.sv
// Input stage: difference vector, special-case flags, half-turn of a
// negative x and scaling into the CORDIC datapath. Depends on dac_pkg.
`default_nettype none

module dac_prep #(
  parameter int unsigned CW = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic signed [CW-1:0]   src_x_i,
  input  logic signed [CW-1:0]   src_y_i,
  input  logic signed [CW-1:0]   src_z_i,
  input  logic signed [CW-1:0]   dst_x_i,
  input  logic signed [CW-1:0]   dst_y_i,
  input  logic signed [CW-1:0]   dst_z_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output dac_pkg::vec_t          vec_o,
  output dac_pkg::yaw_side_t     side_o
);
  import dac_pkg::*;

  localparam int unsigned GUARD = 38 - CW;

  logic signed [CW:0] dx, dy, dz, ax, ay, cx, cy;
  logic               dy_pos, flip;
  vec_t               vec_d, vec_q;
  yaw_side_t          side_d, side_q;
  logic               valid_q;

  always_comb begin
    dx = (CW+1)'(src_x_i) - (CW+1)'(dst_x_i);
    dy = (CW+1)'(src_y_i) - (CW+1)'(dst_y_i);
    dz = (CW+1)'(src_z_i) - (CW+1)'(dst_z_i);
    ax = dx[CW] ? -dx : dx;
    ay = dy[CW] ? -dy : dy;
    dy_pos = !dy[CW] && (dy != '0);
    flip = dx[CW];
    cx = flip ? -dx : dx;
    cy = flip ? -dy : dy;

    vec_d.x = cval_t'(cx) <<< GUARD;
    vec_d.y = cval_t'(cy) <<< GUARD;
    vec_d.z = '0;
    if (flip) begin
      vec_d.z = dy_pos ? deg(DEG_180, TAB_FRAC) : -deg(DEG_180, TAB_FRAC);
    end

    side_d.planar_zero = (dx == '0) && (dy == '0);
    side_d.axis = (dx == '0) || (dy == '0);
    side_d.dz_zero = (dz == '0);
    side_d.dz_pos = !dz[CW] && (dz != '0);
    side_d.dz_s = cval_t'(dz) <<< GUARD;
    if (dy == '0) begin
      side_d.yz_ovr = dx[CW] ? deg(DEG_180, TAB_FRAC) : '0;
      side_d.len_ovr = cval_t'(ax) <<< GUARD;
    end else begin
      side_d.yz_ovr = dy_pos ? deg(DEG_90, TAB_FRAC) : -deg(DEG_90, TAB_FRAC);
      side_d.len_ovr = cval_t'(ay) <<< GUARD;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      vec_q  <= vec_d;
      side_q <= side_d;
    end
  end

  assign valid_o = valid_q;
  assign vec_o   = vec_q;
  assign side_o  = side_q;

endmodule

`default_nettype wire

>>> sv/dac_gain.sv
// Between the two CORDIC rows: yaw rounding and folding, and the planar
// length as a two-stage gain multiply. Depends on dac_pkg, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module dac_gain #(
  parameter int unsigned AFB = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  dac_pkg::vec_t        vec_i,
  input  dac_pkg::yaw_side_t   side_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output dac_pkg::vec_t        vec_o,
  output dac_pkg::pitch_side_t side_o
);
  import dac_pkg::*;

  localparam int PROD_W = PROD_SPLIT + KINV_W;
  localparam int SUM_W = 2 * PROD_SPLIT + KINV_W;
  localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (KINV_SHIFT - 1);

  logic              v1_q, v2_q, r1, r2;
  logic [PROD_W-1:0] plo_d, phi_d, plo_q, phi_q;
  yaw_side_t         side1_q;
  ang_t              yaw_sel, yaw_rnd, fold_d, fold1_q;
  logic [SUM_W-1:0]  sum;
  cval_t             len_raw, len_d;
  vec_t              vec2_d, vec2_q;
  pitch_side_t       side2_d, side2_q;

  always_comb begin
    plo_d = PROD_W'(vec_i.x[PROD_SPLIT-1:0]) * PROD_W'(KINV_Q22);
    phi_d = PROD_W'(vec_i.x[2*PROD_SPLIT-1:PROD_SPLIT]) * PROD_W'(KINV_Q22);
    yaw_sel = side_i.axis ? side_i.yz_ovr : vec_i.z;
    yaw_rnd = round_angle(yaw_sel, AFB);
    if (yaw_rnd > deg(DEG_90, AFB)) begin
      fold_d = yaw_rnd - deg(DEG_180, AFB);
    end else if (yaw_rnd < deg(DEG_90, AFB)) begin
      fold_d = yaw_rnd + deg(DEG_180, AFB);
    end else begin
      fold_d = '0;
    end
  end

  always_comb begin
    sum = {phi_q, PROD_SPLIT'(0)} + SUM_W'(plo_q) + ROUND_HALF;
    len_raw = cval_t'(sum[SUM_W-1:KINV_SHIFT]);
    if (side1_q.axis) begin
      len_d = side1_q.len_ovr;
    end else if (len_raw == '0) begin
      len_d = cval_t'(1);
    end else begin
      len_d = len_raw;
    end
    vec2_d.x = len_d;
    vec2_d.y = side1_q.dz_s;
    vec2_d.z = '0;
    side2_d.planar_zero = side1_q.planar_zero;
    side2_d.dz_pos = side1_q.dz_pos;
    side2_d.dz_zero = side1_q.dz_zero;
    side2_d.yaw_fold = fold1_q;
  end

  assign r2 = !v2_q || ready_i;
  assign r1 = !v1_q || r2;
  assign ready_o = r1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (r1) begin
        v1_q <= valid_i;
      end
      if (r2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && r1) begin
      plo_q   <= plo_d;
      phi_q   <= phi_d;
      side1_q <= side_i;
      fold1_q <= fold_d;
    end
    if (v1_q && r2) begin
      vec2_q  <= vec2_d;
      side2_q <= side2_d;
    end
  end

  assign valid_o = v2_q;
  assign vec_o   = vec2_q;
  assign side_o  = side2_q;

  `DAC_ASSERT_IMPLIES(a_len_positive, v2_q && !side2_q.planar_zero, vec2_q.x > cval_t'(0))
  `DAC_ASSERT_IMPLIES(a_fold_range, v1_q, (fold1_q >= -deg(DEG_90, AFB)) && (fold1_q <= deg(DEG_270, AFB)))

endmodule

`default_nettype wire

>>> sv/dac_finish.sv
// Output stage: pitch rounding and special cases, result register.
// Depends on dac_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module dac_finish #(
  parameter int unsigned AFB = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  dac_pkg::vec_t                vec_i,
  input  dac_pkg::pitch_side_t         side_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output logic [dac_pkg::ANGLE_W-1:0]  pitch_o,
  output logic [dac_pkg::ANGLE_W-1:0]  yaw_o
);
  import dac_pkg::*;

  logic               valid_q;
  ang_t               pitch_w, yaw_w;
  logic [ANGLE_W-1:0] pitch_q, yaw_q;

  always_comb begin
    if (side_i.planar_zero) begin
      pitch_w = side_i.dz_pos ? deg(DEG_270, AFB) : deg(DEG_90, AFB);
      yaw_w = '0;
    end else begin
      pitch_w = side_i.dz_zero ? '0 : round_angle(vec_i.z, AFB);
      yaw_w = side_i.yaw_fold;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      pitch_q <= pitch_w[ANGLE_W-1:0];
      yaw_q   <= yaw_w[ANGLE_W-1:0];
    end
  end

  assign valid_o = valid_q;
  assign pitch_o = pitch_q;
  assign yaw_o   = yaw_q;

  `DAC_ASSERT_IMPLIES(a_pitch_range, valid_i && ready_o, (pitch_w >= deg(DEG_PITCH_MIN, AFB)) && (pitch_w <= deg(DEG_270, AFB)))

endmodule

`default_nettype wire

>>> sv/direction_to_view_angles.sv
// Top level of the view angle block: input stage, two rows of CORDIC
// cells, gain stage and output stage. Depends on dac_pkg and all dac_ modules.
//
// Usage: a word on the slave stream carries a source and a destination
// point; the master stream returns one word with pitch and yaw of the
// vector source minus destination, in degrees with ANGLE_FRAC_BITS
// fraction bits, and zero padding above them.
// From acceptance to the result word a word passes one input register, a
// row of CORDIC_STAGES cells for yaw, two gain-multiply stages, a second
// row of CORDIC_STAGES cells for pitch and the output register.
// Throughput is one word per cycle while the receiver does not stall;
// every stage holds its own valid bit, so a new word enters whenever the
// input register holds a bubble or its word moves on.
// When the receiver stalls, the result stays in the output register and
// the words behind it close up until every stage is full; only then is
// s_axis_tready_o low.
// Reset empties every stage; words in flight are dropped and none is created by it.
`default_nettype none

module direction_to_view_angles #(
  parameter int unsigned COORD_WIDTH     = 24,
  parameter int unsigned CORDIC_STAGES   = 16,
  parameter int unsigned ANGLE_FRAC_BITS = 8,
  localparam int unsigned IN_DATA_W      = ((6 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // src_x, src_y, src_z, dst_x, dst_y, dst_z, zero padding
  input  logic [IN_DATA_W-1:0]             s_axis_tdata_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // pitch_deg, yaw_deg, zero padding
  output logic [dac_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o
);
  import dac_pkg::*;

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned NS = CORDIC_STAGES;
  localparam int YSW = $bits(yaw_side_t);
  localparam int PSW = $bits(pitch_side_t);

  logic        yv [NS+1];
  logic        yr [NS+1];
  vec_t        yvec [NS+1];
  yaw_side_t   ysd [NS+1];
  logic        pv [NS+1];
  logic        pr [NS+1];
  vec_t        pvec [NS+1];
  pitch_side_t psd [NS+1];

  logic [ANGLE_W-1:0] pitch, yaw;

  dac_prep #(.CW(CW)) u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .src_x_i (s_axis_tdata_i[0*CW +: CW]),
    .src_y_i (s_axis_tdata_i[1*CW +: CW]),
    .src_z_i (s_axis_tdata_i[2*CW +: CW]),
    .dst_x_i (s_axis_tdata_i[3*CW +: CW]),
    .dst_y_i (s_axis_tdata_i[4*CW +: CW]),
    .dst_z_i (s_axis_tdata_i[5*CW +: CW]),
    .valid_o (yv[0]),
    .ready_i (yr[0]),
    .vec_o   (yvec[0]),
    .side_o  (ysd[0])
  );

  for (genvar k = 0; k < NS; k++) begin : g_yaw
    dac_cordic_cell #(.STAGE(k), .SIDE_W(YSW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (yv[k]),
      .ready_o (yr[k]),
      .vec_i   (yvec[k]),
      .side_i  (ysd[k]),
      .valid_o (yv[k+1]),
      .ready_i (yr[k+1]),
      .vec_o   (yvec[k+1]),
      .side_o  (ysd[k+1])
    );
  end

  dac_gain #(.AFB(ANGLE_FRAC_BITS)) u_gain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (yv[NS]),
    .ready_o (yr[NS]),
    .vec_i   (yvec[NS]),
    .side_i  (ysd[NS]),
    .valid_o (pv[0]),
    .ready_i (pr[0]),
    .vec_o   (pvec[0]),
    .side_o  (psd[0])
  );

  for (genvar k = 0; k < NS; k++) begin : g_pitch
    dac_cordic_cell #(.STAGE(k), .SIDE_W(PSW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (pv[k]),
      .ready_o (pr[k]),
      .vec_i   (pvec[k]),
      .side_i  (psd[k]),
      .valid_o (pv[k+1]),
      .ready_i (pr[k+1]),
      .vec_o   (pvec[k+1]),
      .side_o  (psd[k+1])
    );
  end

  dac_finish #(.AFB(ANGLE_FRAC_BITS)) u_finish (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pv[NS]),
    .ready_o (pr[NS]),
    .vec_i   (pvec[NS]),
    .side_i  (psd[NS]),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .pitch_o (pitch),
    .yaw_o   (yaw)
  );

  assign m_axis_tdata_o = {(OUT_DATA_W - 2 * ANGLE_W)'(0), yaw, pitch};

endmodule

`default_nettype wire
